/* rtl/core/dtps_pkg.sv */
`timescale 1ns / 1ps

package dtps_pkg;

  localparam int SLOTS        = 16;
  localparam int TASK_ID_BITS = 8;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int START_W = CNT_W + 1;
  localparam int IDENT_W = 8;
  localparam int TIME_W  = 32;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [START_W-1:0]      start_t;
  typedef logic [TASK_ID_BITS-1:0] task_id_t;
  typedef logic [TIME_W-1:0]       time_t;

  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_TICK    = 3'd2;
  localparam logic [2:0] ACT_NEXT    = 3'd3;
  localparam logic [2:0] ACT_OUTCOME = 3'd4;

  localparam logic [1:0] OUT_FINISHED = 2'd0;
  localparam logic [1:0] OUT_REPEAT   = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_NO_DISP = 2'd3;

  typedef struct packed {
    task_id_t task_id;
    time_t    deadline;
    time_t    period;
  } entry_t;

  // broadcast to every cell of the pool
  typedef struct packed {
    logic   load;
    logic   shift;
    logic   rearm;
    time_t  tick;
    start_t start;
    cnt_t   count;
    cnt_t   cursor;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

/* rtl/core/dtps_cell.sv */
`timescale 1ns / 1ps

module dtps_cell (
  input  logic               clk,
  input  dtps_pkg::cell_ctl_t ctl,
  input  dtps_pkg::slot_t    slot_idx,
  input  dtps_pkg::entry_t   right,
  output dtps_pkg::entry_t   entry,
  output logic               due
);
  import dtps_pkg::*;

  cnt_t idx_c;

  assign idx_c = cnt_t'(slot_idx);

  assign due = ({1'b0, idx_c} >= ctl.start) && (idx_c < ctl.count) &&
               (entry.deadline <= ctl.tick);

  always_ff @(posedge clk) begin
    if (ctl.load && (idx_c == ctl.count)) begin
      entry <= ctl.new_entry;
    end else if (ctl.shift && (idx_c >= ctl.cursor) &&
                 ((idx_c + cnt_t'(1)) < ctl.count)) begin
      // take the neighbour's entry to close the gap
      entry <= right;
    end else if (ctl.rearm && (idx_c == ctl.cursor)) begin
      entry.deadline <= ctl.tick + entry.period;
    end
  end

endmodule

/* rtl/core/deadline_task_pool_scheduler_top.sv */
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid / in_ready  | action, task_ident, delay, repeat_period, outcome
// out     | out_valid / out_ready| status, ready_task, ready_slot, pool_count
//
// Each item is captured, then its action runs over the row of pool cells
// (parallel deadline compare, priority pick, shift-left).
// One item is in flight at a time; the result register frees the input side.
// A stalled result holds the execute step until the output register drains.
// Synchronous reset empties the pool, zeroes tick, cursor and pending flag.

module deadline_task_pool_scheduler_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 action,
  input  logic [dtps_pkg::IDENT_W-1:0] task_ident,
  input  dtps_pkg::time_t            delay,
  input  dtps_pkg::time_t            repeat_period,
  input  logic [1:0]                 outcome,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output dtps_pkg::task_id_t         ready_task,
  output dtps_pkg::slot_t            ready_slot,
  output dtps_pkg::cnt_t             pool_count
);
  import dtps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  logic [2:0] act_q;
  task_id_t   ident_q;
  time_t      delay_q;
  time_t      period_q;
  logic [1:0] outc_q;

  cnt_t  count, count_next;
  time_t tick, tick_next;
  cnt_t  cursor, cursor_next;
  logic  pending, pending_next;

  logic [1:0] status_next;
  task_id_t   rtask_next;
  slot_t      rslot_next;

  cell_ctl_t ctl;
  entry_t    entries [SLOTS];
  entry_t    rights  [SLOTS];
  logic [SLOTS-1:0] due;

  logic  found;
  slot_t pick;
  logic  out_free;
  logic  go;
  logic [15:0] ident_wide;

  assign out_free = !out_valid || out_ready;
  assign go       = (state == S_EXEC) && out_free;
  assign in_ready = (state == S_IDLE);
  assign ident_wide = {8'b0, task_ident};

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g + 1 < SLOTS) begin : g_mid
        assign rights[g] = entries[g + 1];
      end else begin : g_end
        assign rights[g] = '0;
      end
      dtps_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .slot_idx (slot_t'(g)),
        .right    (rights[g]),
        .entry    (entries[g]),
        .due      (due[g])
      );
    end
  endgenerate

  // priority pick: lowest due slot wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (due[i]) begin
        found = 1'b1;
        pick  = slot_t'(i);
      end
    end
  end

  always_comb begin
    count_next   = count;
    tick_next    = tick;
    cursor_next  = cursor;
    pending_next = pending;
    status_next  = ST_OK;
    rtask_next   = '0;
    rslot_next   = '0;

    ctl.load      = 1'b0;
    ctl.shift     = 1'b0;
    ctl.rearm     = 1'b0;
    ctl.tick      = tick;
    ctl.start     = {1'b0, cursor} + start_t'(pending);
    ctl.count     = count;
    ctl.cursor    = cursor;
    ctl.new_entry.task_id  = ident_q;
    ctl.new_entry.deadline = tick + delay_q;
    ctl.new_entry.period   = period_q;

    case (act_q)
      ACT_CLEAR: begin
        count_next   = '0;
        tick_next    = '0;
        cursor_next  = '0;
        pending_next = 1'b0;
      end
      ACT_ADD: begin
        if (count < cnt_t'(SLOTS)) begin
          ctl.load   = go;
          count_next = count + cnt_t'(1);
        end else begin
          status_next = ST_FULL;
        end
      end
      ACT_TICK: begin
        tick_next = tick + time_t'(1);
      end
      ACT_NEXT: begin
        pending_next = found;
        if (found) begin
          cursor_next = cnt_t'(pick);
          rtask_next  = entries[pick].task_id;
          rslot_next  = pick;
        end else begin
          cursor_next = '0;
          status_next = ST_NONE;
        end
      end
      ACT_OUTCOME: begin
        pending_next = 1'b0;
        if (!pending || (cursor >= count)) begin
          status_next = ST_NO_DISP;
        end else if (outc_q == OUT_FINISHED) begin
          ctl.shift  = go;
          count_next = count - cnt_t'(1);
        end else begin
          ctl.rearm   = go && (outc_q == OUT_REPEAT);
          cursor_next = cursor + cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      tick      <= '0;
      cursor    <= '0;
      pending   <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            count   <= count_next;
            tick    <= tick_next;
            cursor  <= cursor_next;
            pending <= pending_next;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q    <= action;
      ident_q  <= ident_wide[TASK_ID_BITS-1:0];
      delay_q  <= delay;
      period_q <= repeat_period;
      outc_q   <= outcome;
    end
    if (go) begin
      status     <= status_next;
      ready_task <= rtask_next;
      ready_slot <= rslot_next;
      pool_count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(SLOTS))
    else $error("pool count beyond capacity");

  a_pending_in_pool: assert property (@(posedge clk) disable iff (rst)
    pending |-> (cursor < count))
    else $error("pending dispatch outside the pool");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result raised without an execute step");

  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !out_free) |=> (state == S_EXEC))
    else $error("execute step left while output stalled");

endmodule

/* tb/deadline_task_pool_scheduler_top_tb.sv */
`timescale 1ns / 1ps

module deadline_task_pool_scheduler_top_tb;
  import dtps_pkg::*;

  localparam logic [1:0] OUT_OTHER = 2'd2;
  localparam logic [1:0] OUT_SPARE = 2'd3;
  localparam int QUIET_FROM = 1450;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [1:0] status;
    task_id_t   ready_task;
    slot_t      ready_slot;
    cnt_t       pool_count;
  } sched_reply_t;

  class pool_scoreboard;
    task_id_t     slot_task [SLOTS];
    time_t        slot_deadline [SLOTS];
    time_t        slot_period [SLOTS];
    cnt_t         count;
    time_t        tick;
    cnt_t         cursor;
    bit           pending;
    sched_reply_t awaited_replies [$];
    int           errors;
    int           replies_seen;
    int           n_dispatch;
    int           n_full;
    int           n_empty_pass;
    int           n_no_disp;

    function new();
      count = '0;
      tick = '0;
      cursor = '0;
      pending = 1'b0;
      errors = 0;
      replies_seen = 0;
      n_dispatch = 0;
      n_full = 0;
      n_empty_pass = 0;
      n_no_disp = 0;
    endfunction

    // Work out the reply to one accepted request and update the pool copy.
    function void note_request(logic [2:0] act, logic [IDENT_W-1:0] ident, time_t dly,
                               time_t per, logic [1:0] outc);
      sched_reply_t r;
      start_t       scan;
      bit           found;
      int unsigned  j;
      r = '0;
      case (act)
        ACT_CLEAR: begin
          count = '0;
          tick = '0;
          cursor = '0;
          pending = 1'b0;
        end
        ACT_ADD: begin
          if (count < SLOTS) begin
            slot_task[count] = task_id_t'(ident);
            slot_deadline[count] = tick + dly;
            slot_period[count] = per;
            count = count + 1'b1;
          end else begin
            r.status = ST_FULL;
            n_full++;
          end
        end
        ACT_TICK: tick = tick + 1'b1;
        ACT_NEXT: begin
          // a pending task is skipped over as if left unchanged
          scan = start_t'(cursor) + start_t'(pending);
          pending = 1'b0;
          found = 1'b0;
          j = 32'(scan);
          while (j < count && !found) begin
            if (slot_deadline[j] <= tick) found = 1'b1;
            else j++;
          end
          if (found) begin
            cursor = cnt_t'(j);
            pending = 1'b1;
            r.ready_task = slot_task[j];
            r.ready_slot = slot_t'(j);
            n_dispatch++;
          end else begin
            cursor = '0;
            r.status = ST_NONE;
            n_empty_pass++;
          end
        end
        ACT_OUTCOME: begin
          if (!pending || cursor >= count) begin
            pending = 1'b0;
            r.status = ST_NO_DISP;
            n_no_disp++;
          end else begin
            pending = 1'b0;
            if (outc == OUT_FINISHED) begin
              // shift later entries left; cursor now points at the successor
              for (j = cursor; j + 1 < count; j++) begin
                slot_task[j] = slot_task[j+1];
                slot_deadline[j] = slot_deadline[j+1];
                slot_period[j] = slot_period[j+1];
              end
              count = count - 1'b1;
            end else begin
              if (outc == OUT_REPEAT) slot_deadline[cursor] = tick + slot_period[cursor];
              cursor = cursor + 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.pool_count = count;
      awaited_replies.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_reply(logic [1:0] st, task_id_t rtask, slot_t rslot, cnt_t rcount);
      sched_reply_t e;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none actual status %0h task %0h",
                 $time, st, rtask);
        $display("%0t: unexpected reply slot %0h count %0d", $time, rslot, rcount);
        return;
      end
      e = awaited_replies.pop_front();
      compare_field("status", 32'(e.status), 32'(st));
      compare_field("ready_task", 32'(e.ready_task), 32'(rtask));
      compare_field("ready_slot", 32'(e.ready_slot), 32'(rslot));
      compare_field("pool_count", 32'(e.pool_count), 32'(rcount));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           action = '0;
  logic [IDENT_W-1:0]   task_ident = '0;
  time_t                delay = '0;
  time_t                repeat_period = '0;
  logic [1:0]           outcome = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  task_id_t             ready_task;
  slot_t                ready_slot;
  cnt_t                 pool_count;

  pool_scoreboard sb;
  int  items_sent = 0;
  bit  calm = 1'b1;
  bit  quiet = 1'b0;

  always #6 clk = ~clk;

  deadline_task_pool_scheduler_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .task_ident    (task_ident),
    .delay         (delay),
    .repeat_period (repeat_period),
    .outcome       (outcome),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .ready_task    (ready_task),
    .ready_slot    (ready_slot),
    .pool_count    (pool_count)
  );

  task automatic send_request(input logic [2:0] act, input logic [IDENT_W-1:0] ident,
                              input time_t dly, input time_t per, input logic [1:0] outc);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    task_ident    <= ident;
    delay         <= dly;
    repeat_period <= per;
    outcome       <= outc;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, ident, dly, per, outc);
    if (act <= ACT_OUTCOME) items_sent++;
  endtask

  // mostly near deadlines so that tasks become ready; now and then anywhere
  function automatic time_t pick_span();
    if ($urandom_range(0, 7) == 0) return time_t'($urandom);
    return time_t'($urandom_range(0, 12));
  endfunction

  function automatic logic [1:0] pick_outcome();
    int w;
    w = $urandom_range(0, 9);
    if (w < 4) return OUT_FINISHED;
    if (w < 7) return OUT_REPEAT;
    if (w < 9) return OUT_OTHER;
    return OUT_SPARE;
  endfunction

  task automatic add_task();
    send_request(ACT_ADD, IDENT_W'($urandom), pick_span(), pick_span(), 2'($urandom));
  endtask

  task automatic plain(input logic [2:0] act, input logic [1:0] outc);
    send_request(act, IDENT_W'($urandom), time_t'($urandom), time_t'($urandom), outc);
  endtask

  // fill the pool, then one refused add
  task automatic fill_pool();
    while (sb.count < SLOTS) add_task();
    add_task();
  endtask

  // drain replies with random stall bursts
  initial begin
    int stall;
    stall = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_reply(status, ready_task, ready_slot, pool_count);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    plain(ACT_CLEAR, OUT_FINISHED);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_OUTCOME, OUT_REPEAT);
    plain(ACT_OUTCOME + 3'd3, OUT_FINISHED);
    send_request(ACT_ADD, '0, '0, '1, OUT_FINISHED);
    send_request(ACT_ADD, '1, '1, '0, OUT_FINISHED);
    send_request(ACT_ADD, IDENT_W'(8'hA5), time_t'(1), time_t'(32'h5A5A_5A5A), OUT_FINISHED);
    plain(ACT_TICK, OUT_FINISHED);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_OUTCOME, OUT_REPEAT);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_OUTCOME, OUT_SPARE);
    plain(ACT_NEXT, OUT_FINISHED);
    plain(ACT_OUTCOME, OUT_FINISHED);
    plain(ACT_OUTCOME, OUT_OTHER);
    fill_pool();

    // random sequences
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent >= QUIET_FROM);
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        n = $urandom_range(1, 6);
        repeat (n) add_task();
      end else if (kind < 9) begin
        n = $urandom_range(1, 5);
        repeat (n) plain(ACT_TICK, 2'($urandom));
      end else if (kind < 16) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          plain(ACT_NEXT, 2'($urandom));
          if ($urandom_range(0, 7) != 0) plain(ACT_OUTCOME, pick_outcome());
        end
      end else if (kind < 17) begin
        fill_pool();
      end else begin
        // noise, including spare action codes and clears
        plain(3'($urandom), 2'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d requests and %0d replies: %0d dispatches, %0d refused adds,",
             items_sent, sb.replies_seen, sb.n_dispatch, sb.n_full);
    $display("%0d exhausted passes and %0d outcomes with nothing dispatched.",
             sb.n_empty_pass, sb.n_no_disp);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
